>>> rtl/km2d_pkg.sv
// ----------------------------------------------------------------------------
// km2d_pkg: shared types and constants
// Widths, function codes and the queue entry that links front and back.
// ----------------------------------------------------------------------------
package km2d_pkg;
  localparam int MaxClusters = 8;
  localparam int CoordBits   = 16;
  localparam int FracBits    = 8;
  localparam int MaxPoints   = 65536;
  localparam int IdxBits     = 3;
  localparam int CenBits     = CoordBits + FracBits + 1;   // 25
  localparam int SumBits     = 33;
  localparam int CntBits     = 17;
  localparam int DistBits    = 2 * CenBits + 1;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_POINT = 1'b1;
  localparam logic KIND_ASSIGN = 1'b0;
  localparam logic KIND_CENTER = 1'b1;

  // one classified item handed from the front to the back
  typedef struct packed {
    logic                        func;
    logic [IdxBits-1:0]          idx;
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
    logic                        last;
  } item_t;
endpackage

>>> rtl/kmeans_2d_pass.sv
// ----------------------------------------------------------------------------
// kmeans_2d_pass: one Lloyd k-means pass over 2-D points
// A point scans the n in-use centers one per cycle; a last point also runs
// two bit-serial 41-step divisions per non-empty in-use cluster, none for
// an empty one. Reset is synchronous, active low; it clears centers, sums,
// counts and sets clusters_in_use to 2.
// ----------------------------------------------------------------------------
module kmeans_2d_pass import km2d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // center_index[2:0], coord_x[18:3], coord_y[34:19]
  input  logic        in_tuser,   // func
  input  logic        in_tlast,   // last_point
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // cluster[2:0], center_x[26:3], center_y[50:27],
                                  // unchanged_count[54:51]
  output logic        out_tuser,  // kind
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [3:0] n_used_r;
  item_t      in_item, q_item;
  logic       q_valid, q_ready;
  logic [56:0] od;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {28'd0, n_used_r} : 32'd0;

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) n_used_r <= 4'd2;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
      n_used_r <= cfg_pwdata[3:0];
  end

  assign in_item = '{func: in_tuser, idx: in_tdata[2:0], x: in_tdata[18:3],
                     y: in_tdata[34:19], last: in_tlast};

  km2d_front u_front (.clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
                      .in_item, .q_valid, .q_ready, .q_item);

  km2d_back u_back (.clk, .rst_n, .n_used(n_used_r), .q_valid, .q_ready, .q_item,
                    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(od));

  assign out_tuser = od[0];
  assign out_tdata = {1'b0, od[55:1]};
  assign out_tlast = od[56];
endmodule

>>> rtl/km2d_front.sv
// ----------------------------------------------------------------------------
// km2d_front: input queue
// Accepts input beats into a two-entry queue that the back part drains.
// ----------------------------------------------------------------------------
module km2d_front import km2d_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  q_valid,
  input  logic  q_ready,
  output item_t q_item
);
  item_t       mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // hold entries, advance pointers
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_item;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> rtl/km2d_div.sv
// ----------------------------------------------------------------------------
// km2d_div: signed restoring divider
// Divides a signed 41-bit numerator by an unsigned count, one bit a cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module km2d_div import km2d_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [SumBits+FracBits-1:0] num,
  input  logic [CntBits-1:0]         den,
  output logic                       done,
  output logic signed [CenBits-1:0]  quo
);
  localparam int NB = SumBits + FracBits;
  localparam int SB = $clog2(NB + 1);
  logic [NB-1:0]      q_r;
  logic [CntBits:0]   rem_r;
  logic [CntBits-1:0] den_r;
  logic               neg_r, busy_r;
  logic [SB-1:0]      step_r;
  logic [CntBits:0]   trial;
  logic [NB-1:0]      qn;
  logic [NB-1:0]      mag;

  assign mag   = num[NB-1] ? (~num + 1'b1) : num;
  assign trial = {rem_r[CntBits-1:0], q_r[NB-1]} - {1'b0, den_r};
  assign qn    = neg_r ? (~q_r + 1'b1) : q_r;
  assign quo   = CenBits'(signed'(qn));

  // shift one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      step_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q_r    <= mag;
        rem_r  <= '0;
        den_r  <= den;
        neg_r  <= num[NB-1];
        busy_r <= 1'b1;
        step_r <= SB'(NB);
      end else if (busy_r) begin
        if (!trial[CntBits]) begin
          rem_r <= trial;
          q_r   <= {q_r[NB-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[CntBits-1:0], q_r[NB-1]};
          q_r   <= {q_r[NB-2:0], 1'b0};
        end
        step_r <= step_r - 1'b1;
        if (step_r == SB'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule

>>> rtl/km2d_back.sv
// ----------------------------------------------------------------------------
// km2d_back: assignment and update engine
// Scans in-use centers one per cycle for the nearest, accumulates, and on
// the last point divides each non-empty in-use cluster's sums and emits the in-use centers.
// ----------------------------------------------------------------------------
module km2d_back import km2d_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [3:0]          n_used,
  input  logic                q_valid,
  output logic                q_ready,
  input  item_t               q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [56:0]         out_data
);
  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_ACC = 3'd2, S_EMIT = 3'd3,
                         S_DIVX = 3'd4, S_DIVY = 3'd5, S_OUT = 3'd6, S_WAIT = 3'd7;
  logic [2:0] st_r;

  logic signed [CenBits-1:0] cx_r [MaxClusters];
  logic signed [CenBits-1:0] cy_r [MaxClusters];
  logic signed [SumBits-1:0] sx_r [MaxClusters];
  logic signed [SumBits-1:0] sy_r [MaxClusters];
  logic [CntBits-1:0]        cn_r [MaxClusters];

  item_t                     it_r;
  logic [IdxBits:0]          a_r;
  logic [IdxBits-1:0]        best_r;
  logic [DistBits-1:0]       bd_r;
  logic [3:0]                same_r;
  logic signed [CenBits-1:0] nx_r;
  logic [56:0]               od_r;
  logic                      ov_r;
  logic [3:0]                n;

  // clamp cluster count to 1..8
  always_comb begin
    n = n_used;
    if (n == 4'd0) n = 4'd1;
    if (n > 4'(MaxClusters)) n = 4'(MaxClusters);
  end

  // distance of the held point to center a_r
  logic [IdxBits-1:0]        ai;
  logic signed [CenBits:0]   dx, dy;
  logic [DistBits-1:0]       d;
  assign ai = a_r[IdxBits-1:0];
  assign dx = {{2{it_r.x[CoordBits-1]}}, it_r.x, {FracBits{1'b0}}};
  assign dy = {{2{it_r.y[CoordBits-1]}}, it_r.y, {FracBits{1'b0}}};
  logic signed [CenBits:0] ex, ey;
  logic signed [2*CenBits+1:0] sqx, sqy;
  assign ex  = dx - {cx_r[ai][CenBits-1], cx_r[ai]};
  assign ey  = dy - {cy_r[ai][CenBits-1], cy_r[ai]};
  assign sqx = ex * ex;
  assign sqy = ey * ey;
  assign d   = DistBits'(sqx) + DistBits'(sqy);

  // divider
  logic                              dstart, ddone;
  logic signed [SumBits+FracBits-1:0] dnum;
  logic signed [CenBits-1:0]         dq;
  assign dnum = (st_r == S_DIVY) ? {sy_r[ai], {FracBits{1'b0}}}
                                 : {sx_r[ai], {FracBits{1'b0}}};
  km2d_div u_div (.clk, .rst_n, .start(dstart), .num(dnum), .den(cn_r[ai]),
                  .done(ddone), .quo(dq));

  logic started_r;
  assign dstart  = (st_r == S_DIVX || st_r == S_DIVY) && !started_r &&
                   (cn_r[ai] != '0);
  assign q_ready = (st_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  logic last_c;
  assign last_c = (a_r + 4'd1 == n);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
      started_r <= 1'b0;
      for (int i = 0; i < MaxClusters; i++) begin
        cx_r[i] <= '0; cy_r[i] <= '0; sx_r[i] <= '0; sy_r[i] <= '0; cn_r[i] <= '0;
      end
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (q_valid && !ov_r) begin
            if (q_item.func == FUNC_LOAD) begin
              cx_r[q_item.idx] <= {q_item.x[CoordBits-1], q_item.x, {FracBits{1'b0}}};
              cy_r[q_item.idx] <= {q_item.y[CoordBits-1], q_item.y, {FracBits{1'b0}}};
            end else begin
              it_r <= q_item;
              a_r  <= '0;
              st_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (a_r == '0 || d < bd_r) begin
            bd_r <= d;
            best_r <= ai;
          end
          if (last_c) st_r <= S_ACC;
          a_r <= a_r + 1'b1;
        end
        S_ACC: begin
          if (cn_r[best_r] < CntBits'(MaxPoints)) begin
            sx_r[best_r] <= sx_r[best_r] + SumBits'(it_r.x);
            sy_r[best_r] <= sy_r[best_r] + SumBits'(it_r.y);
            cn_r[best_r] <= cn_r[best_r] + 1'b1;
          end
          od_r <= {!it_r.last, 4'd0, 24'd0, 24'd0, best_r, KIND_ASSIGN};
          ov_r <= 1'b1;
          st_r <= S_EMIT;
        end
        S_EMIT: begin
          if (ov_r && out_ready) begin
            if (!it_r.last) st_r <= S_IDLE;
            else begin
              a_r <= '0;
              same_r <= '0;
              st_r <= S_DIVX;
            end
          end
        end
        S_DIVX, S_DIVY: begin
          if (cn_r[ai] == '0) st_r <= S_OUT;
          else begin
            started_r <= 1'b1;
            if (ddone) begin
              started_r <= 1'b0;
              if (st_r == S_DIVX) begin
                nx_r <= dq;
                st_r <= S_DIVY;
              end else begin
                if (nx_r == cx_r[ai] && dq == cy_r[ai]) same_r <= same_r + 1'b1;
                cx_r[ai] <= nx_r;
                cy_r[ai] <= dq;
                st_r <= S_OUT;
              end
            end
          end
        end
        S_OUT: begin
          od_r <= {last_c, last_c ? same_r : 4'd0, cy_r[ai][23:0], cx_r[ai][23:0],
                   ai, KIND_CENTER};
          ov_r <= 1'b1;
          st_r <= S_WAIT;
        end
        S_WAIT: begin
          if (ov_r && out_ready) begin
            if (last_c) begin
              st_r <= S_IDLE;
              for (int i = 0; i < MaxClusters; i++) begin
                sx_r[i] <= '0; sy_r[i] <= '0; cn_r[i] <= '0;
              end
            end else begin
              a_r <= a_r + 1'b1;
              st_r <= S_DIVX;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
